/* sv/nbl_pkg.sv */
// ----------------------------------------------------------------------------
// nbl_pkg
// Types, source codes and lookup tables for the neighbour block locator.
// ----------------------------------------------------------------------------
`default_nettype none

package nbl_pkg;

    // Neighbour source codes
    typedef logic [2:0] src_t;
    localparam src_t SRC_IN = 3'd0;  // same macroblock
    localparam src_t SRC_A  = 3'd1;  // left macroblock
    localparam src_t SRC_B  = 3'd2;  // upper macroblock
    localparam src_t SRC_C  = 3'd3;  // up-right macroblock
    localparam src_t SRC_D  = 3'd4;  // left-up macroblock
    localparam src_t SRC_X  = 3'd5;  // no neighbour

    localparam int MB_W    = 14;
    localparam int SUB_W   = 4;
    localparam int WIDTH_W = 10;

    typedef logic [MB_W-1:0]    mb_t;
    typedef logic [SUB_W-1:0]   sub_t;
    typedef logic [WIDTH_W-1:0] width_t;

    // Register indexes
    localparam logic REG_WIDTH_IN_MBS   = 1'b0;
    localparam logic REG_SLICE_FIRST_MB = 1'b1;

    // Neighbour sub-block index, [size][direction][sub]
    localparam sub_t NB_SUB_TAB [2][4][16] = '{
        '{
            '{4'd5,  4'd0,  4'd7,  4'd2,  4'd1,  4'd4,  4'd3,  4'd6,
              4'd13, 4'd8,  4'd15, 4'd10, 4'd9,  4'd12, 4'd11, 4'd14},
            '{4'd10, 4'd11, 4'd0,  4'd1,  4'd14, 4'd15, 4'd4,  4'd5,
              4'd2,  4'd3,  4'd8,  4'd9,  4'd6,  4'd7,  4'd12, 4'd13},
            '{4'd11, 4'd14, 4'd1,  4'd4,  4'd15, 4'd10, 4'd5,  4'd0,
              4'd3,  4'd6,  4'd9,  4'd12, 4'd7,  4'd2,  4'd13, 4'd8},
            '{4'd15, 4'd10, 4'd5,  4'd0,  4'd11, 4'd14, 4'd1,  4'd4,
              4'd7,  4'd2,  4'd13, 4'd8,  4'd3,  4'd6,  4'd9,  4'd12}
        },
        '{
            '{4'd1, 4'd0, 4'd3, 4'd2, 4'd0, 4'd0, 4'd0, 4'd0,
              4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd2, 4'd3, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0,
              4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
              4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
            '{4'd3, 4'd2, 4'd1, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0,
              4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0}
        }
    };

    // Neighbour source, [size][direction][sub]
    localparam src_t NB_SRC_TAB [2][4][16] = '{
        '{
            '{SRC_A,  SRC_IN, SRC_A,  SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN,
              SRC_A,  SRC_IN, SRC_A,  SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN},
            '{SRC_B,  SRC_B,  SRC_IN, SRC_IN, SRC_B,  SRC_B,  SRC_IN, SRC_IN,
              SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN},
            '{SRC_B,  SRC_B,  SRC_IN, SRC_IN, SRC_B,  SRC_C,  SRC_IN, SRC_X,
              SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_X,  SRC_IN, SRC_X},
            '{SRC_D,  SRC_B,  SRC_A,  SRC_IN, SRC_B,  SRC_B,  SRC_IN, SRC_IN,
              SRC_A,  SRC_IN, SRC_A,  SRC_IN, SRC_IN, SRC_IN, SRC_IN, SRC_IN}
        },
        '{
            '{SRC_A,  SRC_IN, SRC_A,  SRC_IN, SRC_X,  SRC_X,  SRC_X,  SRC_X,
              SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X},
            '{SRC_B,  SRC_B,  SRC_IN, SRC_IN, SRC_X,  SRC_X,  SRC_X,  SRC_X,
              SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X},
            '{SRC_B,  SRC_C,  SRC_IN, SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,
              SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X},
            '{SRC_D,  SRC_B,  SRC_A,  SRC_IN, SRC_X,  SRC_X,  SRC_X,  SRC_X,
              SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X,  SRC_X}
        }
    };

    // Divider stage payload: remainder of mb / w builds up over stages
    typedef struct packed {
        mb_t    mb;
        sub_t   sub;
        sub_t   nsub;
        src_t   src;
        width_t w;
        width_t rem;
    } div_stg_t;

    // Address stage payload
    typedef struct packed {
        sub_t sub;
        sub_t nsub;
        src_t src;
        logic ok;   // macroblock exists inside the picture
        mb_t  id;   // picture index of the neighbour macroblock
    } adr_stg_t;

    // One restoring division step: shift in a dividend bit, subtract if it fits.
    function automatic width_t div_step(input width_t r, input logic b, input width_t w);
        logic [WIDTH_W:0] t;
        logic [WIDTH_W:0] d;
        t = {r, b};
        d = t - {1'b0, w};
        if (t >= {1'b0, w}) begin
            div_step = d[WIDTH_W-1:0];
        end else begin
            div_step = t[WIDTH_W-1:0];
        end
    endfunction

endpackage

`default_nettype wire

/* sv/h264_neighbour_block_locator.sv */
// Six register stages lie between an input beat and its result beat.
// Throughput: one beat per cycle while the output is not stalled; the remainder
// mb_index mod width is formed by a restoring divider spread over four stages, 2+4+4+4 bits per stage.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Reset (aresetn low, synchronous) clears all valid bits and sets
// width_in_mbs to 1 and slice_first_mb to 0.
// ----------------------------------------------------------------------------
// h264_neighbour_block_locator
// Finds the neighbouring 4x4 / 8x8 block of a sub-block in z-scan order and
// tells whether it is available and in which macroblock it lies.
// ----------------------------------------------------------------------------
`default_nettype none

module h264_neighbour_block_locator #(
    parameter int MAX_PIC_MBS   = 16384,
    parameter int MAX_WIDTH_MBS = 512
) (
    input  wire                   aclk,
    input  wire                   aresetn,

    // configuration write port
    input  wire                   cfg_wr_en,
    input  wire                   cfg_index,
    input  wire  [13:0]           cfg_data,

    // input channel
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  [1:0]            s_opcode,
    input  wire                   s_block_size,
    input  wire  nbl_pkg::mb_t    s_mb_index,
    input  wire  nbl_pkg::sub_t   s_sub_index,

    // result channel
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic                  m_available,
    output logic                  m_in_other_mb,
    output nbl_pkg::mb_t          m_neighbour_mb,
    output nbl_pkg::sub_t         m_neighbour_sub
);

    import nbl_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    width_t width_reg;
    mb_t    sfm_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= width_t'(1);
            sfm_reg   <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_WIDTH_IN_MBS:   width_reg <= cfg_data[WIDTH_W-1:0];
                REG_SLICE_FIRST_MB: sfm_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: every stage moves when the output register is
    // free or being drained. Bubbles travel with a cleared valid bit.
    // ------------------------------------------------------------------
    logic adv;
    logic m_valid_reg;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    logic [4:0] vld_reg;   // valid bits of stages 1..5

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[3:0], s_valid};
            m_valid_reg <= vld_reg[4];
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: table lookup, width clamp, first two divider bits
    // ------------------------------------------------------------------
    div_stg_t st1_next, st1_reg;

    always_comb begin
        width_t wc;
        width_t r;
        if (width_reg == '0) begin
            wc = width_t'(1);
        end else if (int'(width_reg) > MAX_WIDTH_MBS) begin
            wc = width_t'(MAX_WIDTH_MBS);
        end else begin
            wc = width_reg;
        end
        st1_next.mb   = s_mb_index;
        st1_next.sub  = s_sub_index;
        st1_next.nsub = NB_SUB_TAB[s_block_size][s_opcode][s_sub_index];
        // macroblock past the picture never has a neighbour
        if (int'(s_mb_index) >= MAX_PIC_MBS) begin
            st1_next.src = SRC_X;
        end else begin
            st1_next.src = NB_SRC_TAB[s_block_size][s_opcode][s_sub_index];
        end
        st1_next.w = wc;
        r = '0;
        for (int k = 0; k < 2; k++) begin
            r = div_step(r, s_mb_index[MB_W-1-k], wc);
        end
        st1_next.rem = r;
    end

    // ------------------------------------------------------------------
    // Stages 2..4: four divider bits each
    // ------------------------------------------------------------------
    div_stg_t st2_next, st2_reg;
    div_stg_t st3_next, st3_reg;
    div_stg_t st4_next, st4_reg;

    always_comb begin
        width_t r;
        st2_next = st1_reg;
        r = st1_reg.rem;
        for (int k = 0; k < 4; k++) begin
            r = div_step(r, st1_reg.mb[11-k], st1_reg.w);
        end
        st2_next.rem = r;
    end

    always_comb begin
        width_t r;
        st3_next = st2_reg;
        r = st2_reg.rem;
        for (int k = 0; k < 4; k++) begin
            r = div_step(r, st2_reg.mb[7-k], st2_reg.w);
        end
        st3_next.rem = r;
    end

    always_comb begin
        width_t r;
        st4_next = st3_reg;
        r = st3_reg.rem;
        for (int k = 0; k < 4; k++) begin
            r = div_step(r, st3_reg.mb[3-k], st3_reg.w);
        end
        st4_next.rem = r;   // column of the current macroblock
    end

    // ------------------------------------------------------------------
    // Stage 5: picture edge checks and neighbour macroblock index
    // ------------------------------------------------------------------
    adr_stg_t st5_next, st5_reg;

    always_comb begin
        logic top;
        logic left_col;
        logic right_col;
        mb_t  wx;
        wx        = mb_t'(st4_reg.w);
        top       = st4_reg.mb < wx;
        left_col  = st4_reg.rem == '0;
        right_col = st4_reg.rem == (st4_reg.w - width_t'(1));

        st5_next.sub  = st4_reg.sub;
        st5_next.nsub = st4_reg.nsub;
        st5_next.src  = st4_reg.src;
        st5_next.ok   = 1'b0;
        st5_next.id   = '0;
        unique case (st4_reg.src)
            SRC_A: begin
                st5_next.ok = !left_col;
                st5_next.id = st4_reg.mb - mb_t'(1);
            end
            SRC_B: begin
                st5_next.ok = !top;
                st5_next.id = st4_reg.mb - wx;
            end
            SRC_C: begin
                st5_next.ok = !top && !right_col;
                st5_next.id = st4_reg.mb - wx + mb_t'(1);
            end
            SRC_D: begin
                st5_next.ok = !top && !left_col;
                st5_next.id = st4_reg.mb - wx - mb_t'(1);
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // Stage 6: slice start check, result formatting into output register
    // ------------------------------------------------------------------
    logic [MB_W:0] rel_wide;
    logic          avail_next;
    logic          other_next;
    mb_t           nmb_next;
    sub_t          nsub_next;

    assign rel_wide = {1'b0, st5_reg.id} - {1'b0, sfm_reg};  // borrow: before slice

    always_comb begin
        avail_next = 1'b0;
        other_next = 1'b0;
        nmb_next   = '0;
        nsub_next  = '0;
        unique case (st5_reg.src)
            SRC_IN: begin
                // inside the macroblock: only earlier blocks in z-scan
                if (st5_reg.nsub < st5_reg.sub) begin
                    avail_next = 1'b1;
                    nsub_next  = st5_reg.nsub;
                end
            end
            SRC_A, SRC_B, SRC_C, SRC_D: begin
                if (st5_reg.ok && !rel_wide[MB_W]) begin
                    avail_next = 1'b1;
                    other_next = 1'b1;
                    nmb_next   = rel_wide[MB_W-1:0];
                    nsub_next  = st5_reg.nsub;
                end
            end
            default: ;
        endcase
    end

    logic avail_reg;
    logic other_reg;
    mb_t  nmb_reg;
    sub_t nsub_reg;

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (adv) begin
            st1_reg   <= st1_next;
            st2_reg   <= st2_next;
            st3_reg   <= st3_next;
            st4_reg   <= st4_next;
            st5_reg   <= st5_next;
            avail_reg <= avail_next;
            other_reg <= other_next;
            nmb_reg   <= nmb_next;
            nsub_reg  <= nsub_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_available     = avail_reg;
    assign m_in_other_mb   = other_reg;
    assign m_neighbour_mb  = nmb_reg;
    assign m_neighbour_sub = nsub_reg;

endmodule

`default_nettype wire
